// ===== design/lfuft_pkg.sv =====
// Shared constants and types for the LFU frame table.
// No dependencies; compiled first.
`default_nettype none

package lfuft_pkg;

  // Configuration register
  localparam int unsigned CFG_BITS = 5;
  localparam logic [CFG_BITS-1:0] CFG_RESET = 5'd16;

  // Command codes of an input item
  localparam logic CMD_RECOMMEND = 1'b0;
  localparam logic CMD_REPORT    = 1'b1;

  // Result kinds
  localparam int unsigned KIND_BITS = 3;
  localparam logic [KIND_BITS-1:0] KIND_HIT    = 3'd0;
  localparam logic [KIND_BITS-1:0] KIND_PLACED = 3'd1;
  localparam logic [KIND_BITS-1:0] KIND_EVICT  = 3'd2;
  localparam logic [KIND_BITS-1:0] KIND_LISTED = 3'd3;
  localparam logic [KIND_BITS-1:0] KIND_EMPTY  = 3'd4;

  // Write enables of the frame store, one per field memory
  typedef struct packed {
    logic id;
    logic votes;
    logic rank;
  } wr_en_t;

endpackage

`default_nettype wire

// ===== design/lfuft_if.sv =====
// Valid/ready channels for command items and result items.
// Depends on lfuft_pkg.
`default_nettype none

interface lfuft_req_if
  import lfuft_pkg::*;
#(
  parameter int ID_BITS = 8
);
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [ID_BITS-1:0] candidate_id;

  modport source (output valid, cmd, candidate_id, input ready);
  modport sink   (input valid, cmd, candidate_id, output ready);
endinterface

interface lfuft_rsp_if
  import lfuft_pkg::*;
#(
  parameter int ID_BITS   = 8,
  parameter int VOTE_BITS = 16
);
  logic                 valid;
  logic                 ready;
  logic [KIND_BITS-1:0] kind;
  logic [ID_BITS-1:0]   evicted_id;
  logic [ID_BITS-1:0]   listed_id;
  logic [VOTE_BITS-1:0] listed_votes;
  logic                 last;

  modport source (output valid, kind, evicted_id, listed_id, listed_votes, last,
                  input ready);
  modport sink   (input valid, kind, evicted_id, listed_id, listed_votes, last,
                  output ready);
endinterface

`default_nettype wire

// ===== design/lfuft_store.sv =====
// Frame store: id, vote and age-rank memories, one write port and one
// registered read port each. Depends on lfuft_pkg.
`default_nettype none

module lfuft_store
  import lfuft_pkg::*;
#(
  parameter int FRAMES    = 16,
  parameter int ID_BITS   = 8,
  parameter int VOTE_BITS = 16,
  parameter int IDX_BITS  = 4,
  parameter int RANK_BITS = 4
) (
  input  wire logic                 clk,
  input  wire logic [IDX_BITS-1:0]  rd_addr,
  output logic      [ID_BITS-1:0]   rd_id,
  output logic      [VOTE_BITS-1:0] rd_votes,
  output logic      [RANK_BITS-1:0] rd_rank,
  input  wire wr_en_t               wr_en,
  input  wire logic [IDX_BITS-1:0]  wr_addr,
  input  wire logic [ID_BITS-1:0]   wr_id,
  input  wire logic [VOTE_BITS-1:0] wr_votes,
  input  wire logic [RANK_BITS-1:0] wr_rank
);

  logic [ID_BITS-1:0]   mem_id    [FRAMES];
  logic [VOTE_BITS-1:0] mem_votes [FRAMES];
  logic [RANK_BITS-1:0] mem_rank  [FRAMES];

  // Writes
  always_ff @(posedge clk) begin
    if (wr_en.id) begin
      mem_id[wr_addr] <= wr_id;
    end
    if (wr_en.votes) begin
      mem_votes[wr_addr] <= wr_votes;
    end
    if (wr_en.rank) begin
      mem_rank[wr_addr] <= wr_rank;
    end
  end

  // Registered reads
  always_ff @(posedge clk) begin
    rd_id    <= mem_id[rd_addr];
    rd_votes <= mem_votes[rd_addr];
    rd_rank  <= mem_rank[rd_addr];
  end

endmodule

`default_nettype wire

// ===== design/lfu_frame_table_oldest_tiebreak_core.sv =====
// LFU frame table with oldest-first tie-break: sequencer, frame scan unit
// and output register. Depends on lfuft_pkg, lfuft_if and lfuft_store.
//
// Use: req carries one command item (recommend candidate_id, or report);
// rsp returns result items; cfg_we/cfg_data write frames_in_use while idle.
// One item is worked at a time; req.ready is high only between items.
// Each item but an empty-table report walks all FRAMES frames through
// one compare unit, one frame per cycle, reading the frame store at the
// walk address. Recommend, hit: walk, decide, result; free frame: walk,
// decide, place, result.
// Recommend with eviction: a second walk renumbers the age ranks
// before the place step.
// Report: one walk per listed id (smallest id above the last one
// listed); an empty table answers without a walk.
// Results sit in an output register: while the receiver stalls, the
// result holds and the sequencer waits; a new item may be accepted while
// the final result of the previous one is still waiting.
// Reset (rst, synchronous) empties the table and sets frames_in_use to 16;
// no clearing pass is needed, frame contents are gated by valid bits.
`default_nettype none

module lfu_frame_table_oldest_tiebreak_core
  import lfuft_pkg::*;
#(
  parameter int FRAMES    = 16,
  parameter int ID_BITS   = 8,
  parameter int VOTE_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [CFG_BITS-1:0] cfg_data,
  lfuft_req_if.sink                req,
  lfuft_rsp_if.source              rsp
);

  localparam int IDX_BITS  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int RANK_BITS = IDX_BITS;
  localparam int CNT_BITS  = $clog2(FRAMES + 1);
  localparam int LIM_BITS  = (CNT_BITS > CFG_BITS) ? CNT_BITS : CFG_BITS;
  localparam logic [IDX_BITS-1:0]  LAST_IDX = IDX_BITS'(FRAMES - 1);
  localparam logic [VOTE_BITS-1:0] VOTE_MAX = '1;
  localparam logic [VOTE_BITS-1:0] VOTE_ONE = VOTE_BITS'(1);
  localparam logic [LIM_BITS-1:0]  FRAMES_W = LIM_BITS'(FRAMES);

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_SCAN     = 8'b0000_0010,
    ST_DECIDE   = 8'b0000_0100,
    ST_RANK     = 8'b0000_1000,
    ST_PLACE    = 8'b0001_0000,
    ST_RPT      = 8'b0010_0000,
    ST_RPT_DONE = 8'b0100_0000,
    ST_EMIT     = 8'b1000_0000
  } state_t;

  state_t state;

  // Control
  logic [CFG_BITS-1:0] frames_in_use;
  logic [FRAMES-1:0]   frame_valid;
  logic [CNT_BITS-1:0] occ;
  logic [CNT_BITS-1:0] emitted;
  logic                have_last;

  // Walk: issue address, then compare in the next cycle on registered data
  logic                iss;
  logic [IDX_BITS-1:0] cnt;
  logic                ev_on;
  logic                ev_end;
  logic [IDX_BITS-1:0] ev_idx;

  // Item and search results
  logic [ID_BITS-1:0]   cand;
  logic                 hit_f, free_f, vic_f, best_f;
  logic [IDX_BITS-1:0]  hit_idx, free_idx, vic_idx, slot;
  logic [VOTE_BITS-1:0] hit_votes, vic_votes, best_votes;
  logic [RANK_BITS-1:0] vic_rank;
  logic [ID_BITS-1:0]   vic_id, best_id, last_id;

  // Pending result
  logic [KIND_BITS-1:0] res_kind;
  logic [ID_BITS-1:0]   res_ev;
  logic [ID_BITS-1:0]   res_lid;
  logic [VOTE_BITS-1:0] res_votes;
  logic                 res_last;

  // Output register
  logic                 out_valid;
  logic [KIND_BITS-1:0] out_kind;
  logic [ID_BITS-1:0]   out_ev;
  logic [ID_BITS-1:0]   out_lid;
  logic [VOTE_BITS-1:0] out_votes;
  logic                 out_last;

  // Store ports
  logic [ID_BITS-1:0]   rd_id;
  logic [VOTE_BITS-1:0] rd_votes;
  logic [RANK_BITS-1:0] rd_rank;
  wr_en_t               wr_en;
  logic [IDX_BITS-1:0]  wr_addr;
  logic [VOTE_BITS-1:0] wr_votes;
  logic [RANK_BITS-1:0] wr_rank;

  lfuft_store #(
    .FRAMES    (FRAMES),
    .ID_BITS   (ID_BITS),
    .VOTE_BITS (VOTE_BITS),
    .IDX_BITS  (IDX_BITS),
    .RANK_BITS (RANK_BITS)
  ) u_store (
    .clk      (clk),
    .rd_addr  (cnt),
    .rd_id    (rd_id),
    .rd_votes (rd_votes),
    .rd_rank  (rd_rank),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_id    (cand),
    .wr_votes (wr_votes),
    .wr_rank  (wr_rank)
  );

  // Compare unit on the frame under evaluation
  logic ev_valid, id_match, vic_better, best_better, rank_above;
  logic table_full, out_free, take_in;
  logic [LIM_BITS-1:0] occ_w, lim_w;
  logic [VOTE_BITS-1:0] hit_next;

  always_comb begin
    ev_valid    = frame_valid[ev_idx];
    id_match    = ev_valid && (rd_id == cand);
    vic_better  = ev_valid && (!vic_f || (rd_votes < vic_votes) ||
                  ((rd_votes == vic_votes) && (rd_rank < vic_rank)));
    best_better = ev_valid && (!have_last || (rd_id > last_id)) &&
                  (!best_f || (rd_id < best_id));
    rank_above  = ev_valid && (rd_rank > vic_rank);
    hit_next    = (hit_votes == VOTE_MAX) ? hit_votes : hit_votes + VOTE_ONE;
  end

  // Effective limit: zero acts as one, above the table acts as the table
  always_comb begin
    occ_w = LIM_BITS'(occ);
    lim_w = LIM_BITS'(frames_in_use);
    table_full = (occ_w >= FRAMES_W) ||
                 ((lim_w != '0) ? (occ_w >= lim_w) : (occ != '0));
  end

  assign out_free = !out_valid || rsp.ready;
  assign take_in  = req.valid && req.ready;

  // Store writes
  always_comb begin
    wr_en    = '0;
    wr_addr  = ev_idx;
    wr_votes = hit_next;
    wr_rank  = rd_rank - RANK_BITS'(1);
    case (state)
      ST_DECIDE: begin
        if (hit_f) begin
          wr_en.votes = 1'b1;
          wr_addr     = hit_idx;
        end
      end
      ST_RANK: begin
        if (ev_on && rank_above) begin
          wr_en.rank = 1'b1;
        end
      end
      ST_PLACE: begin
        wr_en    = '1;
        wr_addr  = slot;
        wr_votes = VOTE_ONE;
        wr_rank  = RANK_BITS'(occ);
      end
      default: begin
      end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      frames_in_use <= CFG_RESET;
      frame_valid   <= '0;
      occ           <= '0;
      emitted       <= '0;
      have_last     <= 1'b0;
      iss           <= 1'b0;
      cnt           <= '0;
      ev_on         <= 1'b0;
      ev_end        <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        frames_in_use <= cfg_data;
      end

      // walk address and compare stage
      ev_on  <= iss;
      ev_idx <= cnt;
      ev_end <= iss && (cnt == LAST_IDX);
      if (iss) begin
        if (cnt == LAST_IDX) begin
          iss <= 1'b0;
        end else begin
          cnt <= cnt + IDX_BITS'(1);
        end
      end

      if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (take_in) begin
            cand <= req.candidate_id;
            if (req.cmd == CMD_RECOMMEND) begin
              hit_f  <= 1'b0;
              free_f <= 1'b0;
              vic_f  <= 1'b0;
              cnt    <= '0;
              iss    <= 1'b1;
              state  <= ST_SCAN;
            end else if (occ == '0) begin
              res_kind  <= KIND_EMPTY;
              res_ev    <= '0;
              res_lid   <= '0;
              res_votes <= '0;
              res_last  <= 1'b1;
              state     <= ST_EMIT;
            end else begin
              have_last <= 1'b0;
              emitted   <= '0;
              best_f    <= 1'b0;
              cnt       <= '0;
              iss       <= 1'b1;
              state     <= ST_RPT;
            end
          end
        end

        // hit, first free frame and victim in one walk
        ST_SCAN: begin
          if (ev_on) begin
            if (id_match) begin
              hit_f     <= 1'b1;
              hit_idx   <= ev_idx;
              hit_votes <= rd_votes;
            end
            if (!ev_valid && !free_f) begin
              free_f   <= 1'b1;
              free_idx <= ev_idx;
            end
            if (vic_better) begin
              vic_f     <= 1'b1;
              vic_idx   <= ev_idx;
              vic_votes <= rd_votes;
              vic_rank  <= rd_rank;
              vic_id    <= rd_id;
            end
            if (ev_end) begin
              state <= ST_DECIDE;
            end
          end
        end

        ST_DECIDE: begin
          res_lid  <= '0;
          res_last <= 1'b1;
          if (hit_f) begin
            res_kind  <= KIND_HIT;
            res_ev    <= '0;
            res_votes <= hit_next;
            state     <= ST_EMIT;
          end else if (table_full) begin
            // drop the victim, then close the gap in the ranks
            res_kind  <= KIND_EVICT;
            res_ev    <= vic_id;
            res_votes <= VOTE_ONE;
            frame_valid[vic_idx] <= 1'b0;
            occ   <= occ - CNT_BITS'(1);
            slot  <= (!free_f || (vic_idx < free_idx)) ? vic_idx : free_idx;
            cnt   <= '0;
            iss   <= 1'b1;
            state <= ST_RANK;
          end else begin
            res_kind  <= KIND_PLACED;
            res_ev    <= '0;
            res_votes <= VOTE_ONE;
            slot      <= free_idx;
            state     <= ST_PLACE;
          end
        end

        ST_RANK: begin
          if (ev_on && ev_end) begin
            state <= ST_PLACE;
          end
        end

        ST_PLACE: begin
          frame_valid[slot] <= 1'b1;
          occ   <= occ + CNT_BITS'(1);
          state <= ST_EMIT;
        end

        // smallest id above the last one listed
        ST_RPT: begin
          if (ev_on) begin
            if (best_better) begin
              best_f     <= 1'b1;
              best_id    <= rd_id;
              best_votes <= rd_votes;
            end
            if (ev_end) begin
              state <= ST_RPT_DONE;
            end
          end
        end

        ST_RPT_DONE: begin
          res_kind  <= KIND_LISTED;
          res_ev    <= '0;
          res_lid   <= best_id;
          res_votes <= best_votes;
          res_last  <= (CNT_BITS'(emitted + CNT_BITS'(1)) == occ);
          last_id   <= best_id;
          have_last <= 1'b1;
          emitted   <= emitted + CNT_BITS'(1);
          state     <= ST_EMIT;
        end

        ST_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_kind  <= res_kind;
            out_ev    <= res_ev;
            out_lid   <= res_lid;
            out_votes <= res_votes;
            out_last  <= res_last;
            if (res_last) begin
              state <= ST_IDLE;
            end else begin
              best_f <= 1'b0;
              cnt    <= '0;
              iss    <= 1'b1;
              state  <= ST_RPT;
            end
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign req.ready        = (state == ST_IDLE);
  assign rsp.valid        = out_valid;
  assign rsp.kind         = out_kind;
  assign rsp.evicted_id   = out_ev;
  assign rsp.listed_id    = out_lid;
  assign rsp.listed_votes = out_votes;
  assign rsp.last         = out_last;

endmodule

`default_nettype wire

// ===== design/lfuft_checker.sv =====
// Port-level checks for the LFU frame table core, bound to the core module.
// Depends on lfuft_pkg and lfu_frame_table_oldest_tiebreak_core.
`default_nettype none

module lfuft_checker
  import lfuft_pkg::*;
#(
  parameter int ID_BITS   = 8,
  parameter int VOTE_BITS = 16
) (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 req_valid,
  input wire logic                 req_ready,
  input wire logic                 rsp_valid,
  input wire logic                 rsp_ready,
  input wire logic [KIND_BITS-1:0] rsp_kind,
  input wire logic [ID_BITS-1:0]   rsp_evicted_id,
  input wire logic [ID_BITS-1:0]   rsp_listed_id,
  input wire logic [VOTE_BITS-1:0] rsp_listed_votes,
  input wire logic                 rsp_last
);

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) &&
      $stable(rsp_listed_id) && $stable(rsp_listed_votes) && $stable(rsp_last))
    else $error("result changed while stalled");

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("item accepted while busy");

  // recommend and empty-report results are single and final
  a_rec_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_kind == KIND_HIT || rsp_kind == KIND_PLACED ||
      rsp_kind == KIND_EVICT || rsp_kind == KIND_EMPTY) |-> rsp_last &&
      (rsp_listed_id == '0))
    else $error("recommend result not final");

  // a new frame always starts at one vote
  a_new_votes: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_kind == KIND_PLACED || rsp_kind == KIND_EVICT) |->
      (rsp_listed_votes == VOTE_BITS'(1)))
    else $error("new frame vote count wrong");

  // evicted id only on an eviction
  a_evict_id: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_kind != KIND_EVICT) |-> (rsp_evicted_id == '0))
    else $error("evicted id without eviction");

endmodule

bind lfu_frame_table_oldest_tiebreak_core lfuft_checker #(
  .ID_BITS   (ID_BITS),
  .VOTE_BITS (VOTE_BITS)
) u_lfuft_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_kind         (rsp.kind),
  .rsp_evicted_id   (rsp.evicted_id),
  .rsp_listed_id    (rsp.listed_id),
  .rsp_listed_votes (rsp.listed_votes),
  .rsp_last         (rsp.last)
);

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for lfu_frame_table_oldest_tiebreak_core: an LFU frame table
// predictor, valid/ready driver and monitor. Depends on lfuft_pkg, lfuft_if
// and the core RTL.

module tb;
  import lfuft_pkg::*;

  localparam int FRAMES          = 16;
  localparam int ID_BITS         = 8;
  localparam int VOTE_BITS       = 16;
  localparam int IDLE_LIMIT      = 4000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int BACKLOG_CAP     = 16;
  localparam int DRAIN_CYCLES    = 50;

  typedef struct packed {
    logic               cmd;
    logic [ID_BITS-1:0] id;
  } cmd_item_t;

  typedef struct packed {
    logic [KIND_BITS-1:0] kind;
    logic [ID_BITS-1:0]   evicted_id;
    logic [ID_BITS-1:0]   listed_id;
    logic [VOTE_BITS-1:0] votes;
    logic                 last;
  } result_t;

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [CFG_BITS-1:0] cfg_data;

  lfuft_req_if #(.ID_BITS(ID_BITS)) req_ch ();
  lfuft_rsp_if #(.ID_BITS(ID_BITS), .VOTE_BITS(VOTE_BITS)) rsp_ch ();

  lfu_frame_table_oldest_tiebreak_core #(
    .FRAMES(FRAMES),
    .ID_BITS(ID_BITS),
    .VOTE_BITS(VOTE_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // Predicted frame table
  logic                 frame_taken [FRAMES];
  logic [ID_BITS-1:0]   frame_key   [FRAMES];
  logic [VOTE_BITS-1:0] frame_count [FRAMES];
  int unsigned          frame_age   [FRAMES];
  int unsigned          frames_held;
  logic [CFG_BITS-1:0]  limit_copy;

  cmd_item_t cmd_backlog [$];
  result_t   due_results [$];

  int unsigned mismatch_count  = 0;
  bit          item_taken      = 1'b0;
  bit          sender_hold     = 1'b0;
  bit          steady_mode     = 1'b0;
  int unsigned hold_off_asked  = 0;
  int unsigned hold_off_served = 0;
  int unsigned hold_off_left   = 0;
  int unsigned burst_left      = 0;
  int unsigned gap_left        = 0;
  int unsigned stall_mode      = 0;
  int unsigned mode_left       = 0;
  int unsigned idle_cycles     = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // Effective occupancy limit: zero acts as one, above the table acts as full
  function automatic int unsigned frame_limit();
    if (limit_copy == '0) return 1;
    if (limit_copy > FRAMES) return FRAMES;
    return 32'(limit_copy);
  endfunction

  // Apply one command to the predicted table and queue the results it causes
  function automatic void update_frame_table(input cmd_item_t item);
    result_t     r;
    result_t     listing [$];
    int          f;
    int          v;
    int          hit_f;
    int          victim;
    int          slot;
    int unsigned gone_age;
    r      = '0;
    r.last = 1'b1;
    hit_f  = -1;
    victim = -1;
    slot   = -1;
    if (item.cmd == CMD_RECOMMEND) begin
      for (f = 0; f < FRAMES; f++)
        if (frame_taken[f] && frame_key[f] == item.id) hit_f = f;
      if (hit_f >= 0) begin
        // hit: count saturates at all ones
        if (frame_count[hit_f] != '1) frame_count[hit_f]++;
        r.kind  = KIND_HIT;
        r.votes = frame_count[hit_f];
      end else begin
        r.kind = KIND_PLACED;
        if (frames_held >= frame_limit()) begin
          // lowest count loses, oldest among equals
          for (f = 0; f < FRAMES; f++)
            if (frame_taken[f] && (victim < 0 || frame_count[f] < frame_count[victim] ||
                (frame_count[f] == frame_count[victim] && frame_age[f] < frame_age[victim])))
              victim = f;
          gone_age            = frame_age[victim];
          frame_taken[victim] = 1'b0;
          r.evicted_id        = frame_key[victim];
          for (f = 0; f < FRAMES; f++)
            if (frame_taken[f] && frame_age[f] > gone_age) frame_age[f]--;
          frames_held--;
          r.kind = KIND_EVICT;
        end
        for (f = 0; f < FRAMES; f++)
          if (!frame_taken[f] && slot < 0) slot = f;
        frame_taken[slot] = 1'b1;
        frame_key[slot]   = item.id;
        frame_count[slot] = VOTE_BITS'(1);
        frame_age[slot]   = frames_held;
        frames_held++;
        r.votes = VOTE_BITS'(1);
      end
      due_results.insert(due_results.size(), r);
    end else begin
      // report: walk the id space so the listing comes out ascending
      for (v = 0; v < (1 << ID_BITS); v++)
        for (f = 0; f < FRAMES; f++)
          if (frame_taken[f] && frame_key[f] == ID_BITS'(v)) begin
            r.kind      = KIND_LISTED;
            r.listed_id = ID_BITS'(v);
            r.votes     = frame_count[f];
            r.last      = 1'b0;
            listing.insert(listing.size(), r);
          end
      if (listing.size() == 0) begin
        r.kind = KIND_EMPTY;
        due_results.insert(due_results.size(), r);
      end else begin
        listing[listing.size()-1].last = 1'b1;
        foreach (listing[i]) due_results.insert(due_results.size(), listing[i]);
      end
    end
  endfunction

  // Monitor: check results against the oldest expectation, then predict
  always @(posedge clk) begin : monitor
    result_t   want;
    cmd_item_t seen;
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d id %0d",
                                    rsp_ch.kind, rsp_ch.listed_id));
        end else begin
          want = due_results.pop_front();
          if (rsp_ch.kind !== want.kind)
            report_mismatch($sformatf("kind got %0d want %0d", rsp_ch.kind, want.kind));
          if (rsp_ch.evicted_id !== want.evicted_id)
            report_mismatch($sformatf("evicted_id got %0d want %0d",
                                      rsp_ch.evicted_id, want.evicted_id));
          if (rsp_ch.listed_id !== want.listed_id)
            report_mismatch($sformatf("listed_id got %0d want %0d",
                                      rsp_ch.listed_id, want.listed_id));
          if (rsp_ch.listed_votes !== want.votes)
            report_mismatch($sformatf("listed_votes got %0d want %0d",
                                      rsp_ch.listed_votes, want.votes));
          if (rsp_ch.last !== want.last)
            report_mismatch($sformatf("last got %0d want %0d", rsp_ch.last, want.last));
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        seen.cmd = req_ch.cmd;
        seen.id  = req_ch.candidate_id;
        update_frame_table(seen);
        item_taken = 1'b1;
      end
    end
  end

  // Driver: offers backlog items in bursts separated by random gaps
  always @(negedge clk) begin : driver
    bit was_taken;
    was_taken = item_taken;
    if (was_taken) begin
      void'(cmd_backlog.pop_front());
      item_taken = 1'b0;
    end
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || was_taken) begin
      if (gap_left > 0 && !steady_mode) begin
        gap_left--;
        req_ch.valid <= 1'b0;
      end else if (!sender_hold && cmd_backlog.size() > 0) begin
        req_ch.valid        <= 1'b1;
        req_ch.cmd          <= cmd_backlog[0].cmd;
        req_ch.candidate_id <= cmd_backlog[0].id;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: ready pattern switches between modes; long hold-off on request
  always @(negedge clk) begin : receiver
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (hold_off_left > 0) begin
      hold_off_left--;
      rsp_ch.ready <= 1'b0;
    end else if (hold_off_served != hold_off_asked) begin
      hold_off_served = hold_off_asked;
      hold_off_left   = HOLD_OFF_CYCLES;
      rsp_ch.ready <= 1'b0;
    end else if (steady_mode) begin
      rsp_ch.ready <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left  = $urandom_range(16, 96);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0:       rsp_ch.ready <= 1'b1;
        1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
        default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Watchdog: cycles with no handshake on either channel
  always @(posedge clk) begin : watchdog
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Sequence steps run just after the rising edge, clear of driver and monitor
  task automatic step_edge();
    @(posedge clk);
    #1;
  endtask

  task automatic wait_idle();
    while (cmd_backlog.size() != 0 || req_ch.valid || due_results.size() != 0)
      step_edge();
  endtask

  task automatic write_limit(input logic [CFG_BITS-1:0] value);
    wait_idle();
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    limit_copy = value;
    @(negedge clk);
    cfg_we <= 1'b0;
    step_edge();
  endtask

  task automatic push_item(input logic cmd, input logic [ID_BITS-1:0] id);
    cmd_item_t item;
    item.cmd = cmd;
    item.id  = id;
    while (cmd_backlog.size() >= BACKLOG_CAP) step_edge();
    cmd_backlog.insert(cmd_backlog.size(), item);
  endtask

  // Random phase: ids mostly from a pool a little wider than the limit
  task automatic run_phase(input logic [CFG_BITS-1:0] value, input int count,
                           input bit hold_off, input bit pause_mid);
    int unsigned base;
    int unsigned span;
    int          n;
    write_limit(value);
    span = frame_limit() + 4;
    base = $urandom_range(0, (1 << ID_BITS) - 1 - span);
    if (hold_off) hold_off_asked++;
    for (n = 0; n < count; n++) begin
      if (pause_mid && n == count / 2) begin
        // sender waits until every outstanding result is back
        sender_hold = 1'b1;
        while (req_ch.valid || due_results.size() != 0) step_edge();
        sender_hold = 1'b0;
      end
      if ($urandom_range(0, 99) < 12)
        push_item(CMD_REPORT, ID_BITS'($urandom_range(0, 255)));
      else if ($urandom_range(0, 9) < 8)
        push_item(CMD_RECOMMEND, ID_BITS'(base + $urandom_range(0, span - 1)));
      else
        push_item(CMD_RECOMMEND, ID_BITS'($urandom_range(0, 255)));
    end
  endtask

  initial begin : main_seq
    int n;
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_data            = '0;
    req_ch.valid        = 1'b0;
    req_ch.cmd          = CMD_RECOMMEND;
    req_ch.candidate_id = '0;
    rsp_ch.ready        = 1'b0;
    limit_copy          = CFG_RESET;
    frames_held         = 0;
    for (n = 0; n < FRAMES; n++) begin
      frame_taken[n] = 1'b0;
      frame_key[n]   = '0;
      frame_count[n] = '0;
      frame_age[n]   = 0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    step_edge();

    // Directed: empty report, id extremes, hits, then a limit lowered below
    // the occupancy with count ties broken by age
    push_item(CMD_REPORT, 8'h00);
    push_item(CMD_RECOMMEND, 8'h00);
    push_item(CMD_RECOMMEND, 8'hFF);
    push_item(CMD_RECOMMEND, 8'h55);
    push_item(CMD_RECOMMEND, 8'hAA);
    push_item(CMD_RECOMMEND, 8'h00);
    push_item(CMD_RECOMMEND, 8'h00);
    push_item(CMD_REPORT, 8'hFF);
    write_limit(5'd2);
    push_item(CMD_RECOMMEND, 8'h55);
    push_item(CMD_RECOMMEND, 8'h10);
    push_item(CMD_RECOMMEND, 8'h11);
    push_item(CMD_REPORT, 8'h00);
    // zero limit acts as one
    write_limit(5'd0);
    push_item(CMD_RECOMMEND, 8'h12);
    push_item(CMD_REPORT, 8'h00);
    // limit above the table acts as the full table
    write_limit(5'd31);
    push_item(CMD_RECOMMEND, 8'h13);
    push_item(CMD_RECOMMEND, 8'h14);
    push_item(CMD_RECOMMEND, 8'h12);
    push_item(CMD_REPORT, 8'h00);

    // Steady run at full rate: one id hit over and over
    write_limit(5'd16);
    steady_mode = 1'b1;
    for (n = 0; n < 20; n++) push_item(CMD_RECOMMEND, 8'h3C);
    push_item(CMD_REPORT, 8'h00);
    wait_idle();
    steady_mode = 1'b0;

    // Random phases over several limits, extremes and lowered limits included
    run_phase(5'd1, 55, 1'b0, 1'b0);
    run_phase(5'd0, 55, 1'b0, 1'b0);
    run_phase(5'd31, 55, 1'b1, 1'b0);
    run_phase(5'd5, 55, 1'b0, 1'b1);
    run_phase(5'd16, 55, 1'b0, 1'b0);
    run_phase(5'd3, 55, 1'b0, 1'b0);
    run_phase(5'd17, 55, 1'b0, 1'b0);
    run_phase(5'd8, 55, 1'b1, 1'b1);

    wait_idle();
    repeat (DRAIN_CYCLES) step_edge();
    if (due_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", due_results.size()));
    if (mismatch_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
